// ===== src/bounded_ordered_list_evict_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list filter
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_EVICT_FILTER_TOP_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_EVICT_FILTER_TOP_DEFINES_SVH

// Same-cycle implication
`define BOL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list check failed");

// Next-cycle implication
`define BOL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list check failed");

`endif

// ===== src/bol_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list filter package
// Command and status codes, kind limits and cell control words.
// ----------------------------------------------------------------------------
package bol_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT    = 2'd0,
      CMD_REMOVE_AT = 2'd1,
      CMD_PURGE     = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EVICT    = 2'd1,
      ST_NO_INDEX = 2'd2,
      ST_BAD_KIND = 2'd3
   } status_type;

   // How a cell decides that it lies at or beyond the removal point
   typedef enum logic [1:0] {
      MARK_ALL  = 2'd0,
      MARK_POS  = 2'd1,
      MARK_KIND = 2'd2
   } mark_type;

   typedef logic [2:0]  kind_type;
   typedef logic [15:0] handle_type;
   typedef logic [4:0]  count_type;

   localparam kind_type KIND_MIN = 3'd1;
   localparam kind_type KIND_MAX = 3'd4;
   localparam count_type CAP_RESET = 5'd16;

   // Selection of the mark, fed to every cell
   typedef struct packed {
      mark_type mode;
      kind_type kind;
   } sel_type;

   // Update of the row in this cycle
   typedef struct packed {
      logic       shift;
      logic       load;
      kind_type   kind;
      handle_type handle;
   } ctl_type;

   function automatic logic kind_ok(input kind_type k);
      return (k >= KIND_MIN) && (k <= KIND_MAX);
   endfunction

endpackage

// ===== src/bol_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry; takes its upper neighbour's entry when the shift mark
// reaches it, or loads a new entry at its own index.
// ----------------------------------------------------------------------------
module bol_cell #(
   parameter int TABLE_DEPTH = 16,
   parameter int INDEX       = 0
) (
   input  logic                                  clock,
   input  bol_pkg::ctl_type                      ctl,
   input  bol_pkg::sel_type                      sel,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        mark_idx,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        load_idx,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]      cnt,
   input  bol_pkg::kind_type                     nxt_kind,
   input  bol_pkg::handle_type                   nxt_handle,
   input  logic                                  prefix_in,
   output logic                                  prefix_out,
   output bol_pkg::kind_type                     kind,
   output bol_pkg::handle_type                   handle
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   bol_pkg::kind_type   kind_ff, kind_in;
   bol_pkg::handle_type handle_ff, handle_in;
   logic                mark;
   logic                held;

   assign held = cnt_type'(INDEX) < cnt;

   // Decide whether the removal point lies here
   always_comb begin
      unique case (sel.mode)
         bol_pkg::MARK_ALL:  mark = 1'b1;
         bol_pkg::MARK_POS:  mark = (idx_type'(INDEX) == mark_idx);
         bol_pkg::MARK_KIND: mark = held && (kind_ff == sel.kind);
         default:            mark = 1'b0;
      endcase
   end

   assign prefix_out = prefix_in | mark;

   // Load has priority over the shift from the neighbour
   always_comb begin
      kind_in   = kind_ff;
      handle_in = handle_ff;
      priority if (ctl.load && (load_idx == idx_type'(INDEX))) begin
         kind_in   = ctl.kind;
         handle_in = ctl.handle;
      end else if (ctl.shift && prefix_out) begin
         kind_in   = nxt_kind;
         handle_in = nxt_handle;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      handle_ff <= handle_in;
   end

   assign kind   = kind_ff;
   assign handle = handle_ff;

endmodule

// ===== src/bol_row.sv =====
// ----------------------------------------------------------------------------
// Ordered list row
// Chain of cells with the shift mark rippling from index zero upward, and
// the read taps at the head and at a chosen index.
// ----------------------------------------------------------------------------
module bol_row #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                  clock,
   input  bol_pkg::ctl_type                      ctl,
   input  bol_pkg::sel_type                      sel,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        mark_idx,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        load_idx,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]      cnt,
   output logic                                  found,
   output bol_pkg::handle_type                   head_handle,
   output bol_pkg::kind_type                     rd_kind,
   output bol_pkg::handle_type                   rd_handle
);

   bol_pkg::kind_type   kind_w   [TABLE_DEPTH];
   bol_pkg::handle_type handle_w [TABLE_DEPTH];
   logic                prefix_w [TABLE_DEPTH+1];

   assign prefix_w[0] = 1'b0;

   // Build the chain; the top cell refeeds itself
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      bol_pkg::kind_type   up_kind;
      bol_pkg::handle_type up_handle;

      if (i == TABLE_DEPTH - 1) begin : g_top
         assign up_kind   = kind_w[i];
         assign up_handle = handle_w[i];
      end else begin : g_mid
         assign up_kind   = kind_w[i+1];
         assign up_handle = handle_w[i+1];
      end

      bol_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .sel        (sel),
         .mark_idx   (mark_idx),
         .load_idx   (load_idx),
         .cnt        (cnt),
         .nxt_kind   (up_kind),
         .nxt_handle (up_handle),
         .prefix_in  (prefix_w[i]),
         .prefix_out (prefix_w[i+1]),
         .kind       (kind_w[i]),
         .handle     (handle_w[i])
      );
   end

   assign found       = prefix_w[TABLE_DEPTH];
   assign head_handle = handle_w[0];
   assign rd_kind     = kind_w[mark_idx];
   assign rd_handle   = handle_w[mark_idx];

endmodule

// ===== src/bounded_ordered_list_evict_filter_top.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered list with oldest-entry eviction
// Insert, remove at index, remove all of a kind and read at index on a
// chain of entry cells, one result word per request word.
// ----------------------------------------------------------------------------
//   channel   ports                                        direction
//   req       req_valid/ready, command kind handle pos     in
//   rsp       rsp_valid/ready, status counts handles kind  out
//   csr       csr_we, csr_wdata (active capacity)          in
//
// An insert evicting more than one entry steps through S_EVICT, a purge
// through S_PURGE, with one shift of the cell chain per removed entry;
// other words go straight to S_FIN. One request word is in work at a time.
// Synchronous reset empties the list and sets capacity 16; stored entries
// are not cleared. A stalled result holds the next word back until taken.
// ----------------------------------------------------------------------------
module bounded_ordered_list_evict_filter_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_handle,
   input  logic [3:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_entry_count,
   output logic [4:0]  rsp_removed_count,
   output logic [15:0] rsp_released_handle,
   output logic [2:0]  rsp_read_kind,
   output logic [15:0] rsp_read_handle,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   `include "bounded_ordered_list_evict_filter_top_defines.svh"

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [CMP_W-1:0] cmp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVICT,
      S_PURGE,
      S_FIN
   } state_type;

   state_type             state_ff, state_in;
   cnt_type               cnt_ff, cnt_in;
   cnt_type               left_ff, left_in;
   bol_pkg::count_type    cap_ff;
   bol_pkg::kind_type     op_kind_ff, op_kind_in;
   bol_pkg::handle_type   op_handle_ff, op_handle_in;
   bol_pkg::status_type   status_ff, status_in;
   cnt_type               removed_ff, removed_in;
   bol_pkg::handle_type   released_ff, released_in;
   bol_pkg::kind_type     rkind_ff, rkind_in;
   bol_pkg::handle_type   rhandle_ff, rhandle_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bol_pkg::status_type   rsp_status_ff, rsp_status_in;
   bol_pkg::count_type    rsp_cnt_ff, rsp_cnt_in;
   bol_pkg::count_type    rsp_removed_ff, rsp_removed_in;
   bol_pkg::handle_type   rsp_released_ff, rsp_released_in;
   bol_pkg::kind_type     rsp_rkind_ff, rsp_rkind_in;
   bol_pkg::handle_type   rsp_rhandle_ff, rsp_rhandle_in;

   logic                  accept;
   logic                  pos_out;
   cnt_type               eff_cap;
   bol_pkg::ctl_type      ctl;
   bol_pkg::sel_type      sel;
   idx_type               mark_idx;
   idx_type               load_idx;
   logic                  found;
   bol_pkg::handle_type   head_handle;
   bol_pkg::kind_type     rd_kind;
   bol_pkg::handle_type   rd_handle;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign pos_out   = cmp_type'(req_position) >= cmp_type'(cnt_ff);
   assign mark_idx  = idx_type'(req_position);

   // Clamp the capacity into one to the table depth
   always_comb begin
      priority if (cap_ff == '0) begin
         eff_cap = cnt_type'(1);
      end else if (int'(cap_ff) > TABLE_DEPTH) begin
         eff_cap = cnt_type'(TABLE_DEPTH);
      end else begin
         eff_cap = cnt_type'(cap_ff);
      end
   end

   // Mark mode depends on state and command only; the kind comes from op_kind_ff
   always_comb begin
      sel.kind = op_kind_ff;
      if (state_ff == S_PURGE) begin
         sel.mode = bol_pkg::MARK_KIND;
      end else if ((state_ff == S_IDLE) &&
                   (bol_pkg::cmd_type'(req_command) == bol_pkg::CMD_REMOVE_AT)) begin
         sel.mode = bol_pkg::MARK_POS;
      end else begin
         sel.mode = bol_pkg::MARK_ALL;
      end
   end

   // Sequence the operation and the result word
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      left_in         = left_ff;
      op_kind_in      = op_kind_ff;
      op_handle_in    = op_handle_ff;
      status_in       = status_ff;
      removed_in      = removed_ff;
      released_in     = released_ff;
      rkind_in        = rkind_ff;
      rhandle_in      = rhandle_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_cnt_in      = rsp_cnt_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_released_in = rsp_released_ff;
      rsp_rkind_in    = rsp_rkind_ff;
      rsp_rhandle_in  = rsp_rhandle_ff;
      ctl.shift       = 1'b0;
      ctl.load        = 1'b0;
      ctl.kind        = op_kind_ff;
      ctl.handle      = op_handle_ff;
      load_idx        = idx_type'(cnt_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_kind_in   = req_kind;
               op_handle_in = req_handle;
               status_in    = bol_pkg::ST_OK;
               removed_in   = '0;
               released_in  = '0;
               rkind_in     = '0;
               rhandle_in   = '0;
               state_in     = S_FIN;
               ctl.kind     = req_kind;
               ctl.handle   = req_handle;
               unique case (bol_pkg::cmd_type'(req_command))
                  bol_pkg::CMD_INSERT: begin
                     if (!bol_pkg::kind_ok(req_kind)) begin
                        status_in = bol_pkg::ST_BAD_KIND;
                     end else if (cnt_ff >= eff_cap) begin
                        // drop the oldest; append in the same cycle if one suffices
                        status_in   = bol_pkg::ST_EVICT;
                        removed_in  = cnt_ff - eff_cap + cnt_type'(1);
                        released_in = head_handle;
                        ctl.shift   = 1'b1;
                        if (cnt_ff == eff_cap) begin
                           ctl.load = 1'b1;
                           load_idx = idx_type'(cnt_ff - cnt_type'(1));
                        end else begin
                           cnt_in   = cnt_ff - cnt_type'(1);
                           left_in  = cnt_ff - eff_cap;
                           state_in = S_EVICT;
                        end
                     end else begin
                        ctl.load = 1'b1;
                        cnt_in   = cnt_ff + cnt_type'(1);
                     end
                  end
                  bol_pkg::CMD_REMOVE_AT: begin
                     if (pos_out) begin
                        status_in = bol_pkg::ST_NO_INDEX;
                     end else begin
                        released_in = rd_handle;
                        removed_in  = cnt_type'(1);
                        ctl.shift   = 1'b1;
                        cnt_in      = cnt_ff - cnt_type'(1);
                     end
                  end
                  bol_pkg::CMD_PURGE: begin
                     if (!bol_pkg::kind_ok(req_kind)) begin
                        status_in = bol_pkg::ST_BAD_KIND;
                     end else begin
                        state_in = S_PURGE;
                     end
                  end
                  bol_pkg::CMD_READ: begin
                     if (pos_out) begin
                        status_in = bol_pkg::ST_NO_INDEX;
                     end else begin
                        rkind_in   = rd_kind;
                        rhandle_in = rd_handle;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_EVICT: begin
            // drop one more oldest entry; append on the last step
            ctl.shift = 1'b1;
            if (left_ff == cnt_type'(1)) begin
               ctl.load = 1'b1;
               load_idx = idx_type'(cnt_ff - cnt_type'(1));
               state_in = S_FIN;
            end else begin
               cnt_in  = cnt_ff - cnt_type'(1);
               left_in = left_ff - cnt_type'(1);
            end
         end
         S_PURGE: begin
            // close the lowest matching entry, until none is left
            if (found) begin
               ctl.shift  = 1'b1;
               cnt_in     = cnt_ff - cnt_type'(1);
               removed_in = removed_ff + cnt_type'(1);
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_cnt_in      = bol_pkg::count_type'(cnt_ff);
               rsp_removed_in  = bol_pkg::count_type'(removed_ff);
               rsp_released_in = released_ff;
               rsp_rkind_in    = rkind_ff;
               rsp_rhandle_in  = rhandle_ff;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, counts and the result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         left_ff      <= '0;
         cap_ff       <= bol_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
      op_kind_ff      <= op_kind_in;
      op_handle_ff    <= op_handle_in;
      status_ff       <= status_in;
      removed_ff      <= removed_in;
      released_ff     <= released_in;
      rkind_ff        <= rkind_in;
      rhandle_ff      <= rhandle_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_cnt_ff      <= rsp_cnt_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_released_ff <= rsp_released_in;
      rsp_rkind_ff    <= rsp_rkind_in;
      rsp_rhandle_ff  <= rsp_rhandle_in;
   end

   bol_row #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_row (
      .clock       (clock),
      .ctl         (ctl),
      .sel         (sel),
      .mark_idx    (mark_idx),
      .load_idx    (load_idx),
      .cnt         (cnt_ff),
      .found       (found),
      .head_handle (head_handle),
      .rd_kind     (rd_kind),
      .rd_handle   (rd_handle)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_count     = rsp_cnt_ff;
   assign rsp_removed_count   = rsp_removed_ff;
   assign rsp_released_handle = rsp_released_ff;
   assign rsp_read_kind       = rsp_rkind_ff;
   assign rsp_read_handle     = rsp_rhandle_ff;

   `BOL_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, int'(cnt_ff) <= TABLE_DEPTH)
   `BOL_ASSERT_NEXT(a_read_keeps_cnt, clock, reset, accept && (req_command == bol_pkg::CMD_READ), $stable(cnt_ff))
   `BOL_ASSERT_NEXT(a_purge_step, clock, reset, (state_ff == S_PURGE) && found, cnt_ff == cnt_type'($past(cnt_ff) - cnt_type'(1)))
   `BOL_ASSERT_IMPL(a_no_index_clean, clock, reset, rsp_valid_ff && (rsp_status_ff == bol_pkg::ST_NO_INDEX), (rsp_removed_ff == '0) && (rsp_rhandle_ff == '0) && (rsp_released_ff == '0))

endmodule

// ===== test/bounded_ordered_list_evict_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the bounded ordered list with oldest-entry eviction
// Drives a short table of directed request words, then phases of random
// words under several capacities. Each result word is compared with a fixed
// table entry or a testbench shadow of the list. Both channels idle at random.
// ----------------------------------------------------------------------------
module bounded_ordered_list_evict_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 16;
   // Leave margin after the last word for a purge of a full list to finish
   localparam int SETTLE_CYCLES = 24;

   // One result word as the block reports it
   typedef struct packed {
      bol_pkg::status_type status;
      bol_pkg::count_type  entry_count;
      bol_pkg::count_type  removed_count;
      bol_pkg::handle_type released_handle;
      bol_pkg::kind_type   read_kind;
      bol_pkg::handle_type read_handle;
   } outcome_type;

   typedef enum logic {STEP_WORD, STEP_CAP} step_kind_type;

   // One row of the directed table: a request word or a capacity write
   typedef struct {
      step_kind_type       what;
      bol_pkg::count_type  cap_value;
      bol_pkg::cmd_type    cmd;
      bol_pkg::kind_type   kind;
      bol_pkg::handle_type handle;
      logic [3:0]          pos;
      logic                fixed;
      outcome_type         fixed_outcome;
   } plan_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_handle = '0;
   logic [3:0]  req_position = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_entry_count;
   logic [4:0]  rsp_removed_count;
   logic [15:0] rsp_released_handle;
   logic [2:0]  rsp_read_kind;
   logic [15:0] rsp_read_handle;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;

   // Shadow of the list and its capacity
   bol_pkg::kind_type   shadow_kind [TABLE_DEPTH];
   bol_pkg::handle_type shadow_handle [TABLE_DEPTH];
   int unsigned         shadow_len = 0;
   bol_pkg::count_type  shadow_cap = bol_pkg::CAP_RESET;

   outcome_type   pending_outcomes [$];
   int unsigned   mismatch_count = 0;
   logic          steady_run = 1'b0;
   plan_step_type plan [$];

   bounded_ordered_list_evict_filter_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_kind           (req_kind),
      .req_handle         (req_handle),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_removed_count  (rsp_removed_count),
      .rsp_released_handle(rsp_released_handle),
      .rsp_read_kind      (rsp_read_kind),
      .rsp_read_handle    (rsp_read_handle),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request word to the shadow list and return its result word
   function automatic outcome_type table_apply(input bol_pkg::cmd_type op,
                                               input bol_pkg::kind_type k,
                                               input bol_pkg::handle_type h,
                                               input logic [3:0] p);
      outcome_type o;
      int unsigned lim;
      int unsigned n;
      int unsigned i;
      logic        kind_good;
      o = '0;
      kind_good = (k >= bol_pkg::KIND_MIN) && (k <= bol_pkg::KIND_MAX);
      unique case (op)
         bol_pkg::CMD_INSERT: begin
            if (!kind_good) begin
               o.status = bol_pkg::ST_BAD_KIND;
            end else begin
               if (shadow_cap == 0)
                  lim = 1;
               else if (shadow_cap > TABLE_DEPTH)
                  lim = TABLE_DEPTH;
               else
                  lim = shadow_cap;
               // Evict enough of the oldest entries for the new one to fit
               if (shadow_len >= lim) begin
                  n = shadow_len - lim + 1;
                  o.status = bol_pkg::ST_EVICT;
                  o.removed_count = bol_pkg::count_type'(n);
                  o.released_handle = shadow_handle[0];
                  for (i = 0; i + n < shadow_len; i++) begin
                     shadow_kind[i] = shadow_kind[i + n];
                     shadow_handle[i] = shadow_handle[i + n];
                  end
                  shadow_len -= n;
               end
               shadow_kind[shadow_len] = k;
               shadow_handle[shadow_len] = h;
               shadow_len++;
            end
         end
         bol_pkg::CMD_REMOVE_AT: begin
            if (p >= shadow_len) begin
               o.status = bol_pkg::ST_NO_INDEX;
            end else begin
               o.released_handle = shadow_handle[p];
               o.removed_count = 5'd1;
               for (i = p; i + 1 < shadow_len; i++) begin
                  shadow_kind[i] = shadow_kind[i + 1];
                  shadow_handle[i] = shadow_handle[i + 1];
               end
               shadow_len--;
            end
         end
         bol_pkg::CMD_PURGE: begin
            if (!kind_good) begin
               o.status = bol_pkg::ST_BAD_KIND;
            end else begin
               // Compact the survivors towards the front, keeping their order
               n = 0;
               for (i = 0; i < shadow_len; i++) begin
                  if (shadow_kind[i] == k) begin
                     n++;
                  end else begin
                     shadow_kind[i - n] = shadow_kind[i];
                     shadow_handle[i - n] = shadow_handle[i];
                  end
               end
               shadow_len -= n;
               o.removed_count = bol_pkg::count_type'(n);
            end
         end
         default: begin
            if (p >= shadow_len) begin
               o.status = bol_pkg::ST_NO_INDEX;
            end else begin
               o.read_kind = shadow_kind[p];
               o.read_handle = shadow_handle[p];
            end
         end
      endcase
      o.entry_count = bol_pkg::count_type'(shadow_len);
      return o;
   endfunction

   function automatic plan_step_type open_word(input bol_pkg::cmd_type op,
                                               input bol_pkg::kind_type k,
                                               input bol_pkg::handle_type h,
                                               input logic [3:0] p);
      plan_step_type s;
      s.what = STEP_WORD;
      s.cap_value = '0;
      s.cmd = op;
      s.kind = k;
      s.handle = h;
      s.pos = p;
      s.fixed = 1'b0;
      s.fixed_outcome = '0;
      return s;
   endfunction

   // Word whose result is plain: given status and count, every other field zero
   function automatic plan_step_type fixed_word(input bol_pkg::cmd_type op,
                                                input bol_pkg::kind_type k,
                                                input bol_pkg::handle_type h,
                                                input logic [3:0] p,
                                                input bol_pkg::status_type st,
                                                input bol_pkg::count_type n);
      plan_step_type s;
      s = open_word(op, k, h, p);
      s.fixed = 1'b1;
      s.fixed_outcome.status = st;
      s.fixed_outcome.entry_count = n;
      return s;
   endfunction

   function automatic plan_step_type cap_step(input bol_pkg::count_type v);
      plan_step_type s;
      s = open_word(bol_pkg::CMD_READ, '0, '0, '0);
      s.what = STEP_CAP;
      s.cap_value = v;
      return s;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // Offer one request word; starts and returns at a falling edge
   task automatic send_word(input bol_pkg::cmd_type op, input bol_pkg::kind_type k,
                            input bol_pkg::handle_type h,
                            input logic [3:0] p, input logic fixed,
                            input outcome_type fixed_outcome);
      outcome_type o;
      if (!steady_run && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= op;
      req_kind <= k;
      req_handle <= h;
      req_position <= p;
      do @(posedge clock); while (!req_ready);
      o = table_apply(op, k, h, p);
      pending_outcomes.push_back(fixed ? fixed_outcome : o);
      @(negedge clock);
   endtask

   // Hold off the sender until every result word is back and the block is quiet
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_capacity(input bol_pkg::count_type v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      shadow_cap = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Result side: stall at random with a chance of about 8 percent, not in steady runs
   always @(negedge clock) begin
      rsp_ready <= steady_run || ($urandom_range(99) >= 8);
   end

   // Compare every accepted result word with the oldest pending one
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t ns: result word with none expected, status %0h count %0h",
                     $time, rsp_status, rsp_entry_count);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("entry_count", want.entry_count, rsp_entry_count);
            check_field("removed_count", want.removed_count, rsp_removed_count);
            check_field("released_handle", want.released_handle, rsp_released_handle);
            check_field("read_kind", want.read_kind, rsp_read_kind);
            check_field("read_handle", want.read_handle, rsp_read_handle);
         end
      end
   end

   // Stimulus
   initial begin
      int unsigned         ph;
      int unsigned         j;
      int unsigned         roll;
      int unsigned         ins_weight;
      bol_pkg::cmd_type    op;
      bol_pkg::kind_type   k;
      bol_pkg::handle_type h;
      logic [3:0]          p;
      bol_pkg::count_type  phase_cap [10];

      // Directed table: empty list, bad kinds, then capacity clamping and eviction
      plan.push_back(fixed_word(bol_pkg::CMD_READ, 3'd0, 16'h0000, 4'd0,
                                bol_pkg::ST_NO_INDEX, 5'd0));
      plan.push_back(fixed_word(bol_pkg::CMD_REMOVE_AT, 3'd7, 16'hffff, 4'd15,
                                bol_pkg::ST_NO_INDEX, 5'd0));
      plan.push_back(fixed_word(bol_pkg::CMD_INSERT, 3'd0, 16'hffff, 4'd0,
                                bol_pkg::ST_BAD_KIND, 5'd0));
      plan.push_back(fixed_word(bol_pkg::CMD_INSERT, 3'd7, 16'h0000, 4'd15,
                                bol_pkg::ST_BAD_KIND, 5'd0));
      plan.push_back(fixed_word(bol_pkg::CMD_PURGE, 3'd0, 16'h0000, 4'd0,
                                bol_pkg::ST_BAD_KIND, 5'd0));
      plan.push_back(fixed_word(bol_pkg::CMD_PURGE, 3'd5, 16'h0000, 4'd0,
                                bol_pkg::ST_BAD_KIND, 5'd0));
      plan.push_back(fixed_word(bol_pkg::CMD_PURGE, 3'd3, 16'h0000, 4'd0,
                                bol_pkg::ST_OK, 5'd0));
      plan.push_back(fixed_word(bol_pkg::CMD_INSERT, 3'd1, 16'h0000, 4'd0,
                                bol_pkg::ST_OK, 5'd1));
      plan.push_back(fixed_word(bol_pkg::CMD_INSERT, 3'd4, 16'hffff, 4'd15,
                                bol_pkg::ST_OK, 5'd2));
      plan.push_back(open_word(bol_pkg::CMD_READ, 3'd0, 16'h0000, 4'd1));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd2, 16'h1234, 4'd0));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd3, 16'habcd, 4'd0));
      plan.push_back(open_word(bol_pkg::CMD_PURGE, 3'd4, 16'h0000, 4'd0));
      plan.push_back(open_word(bol_pkg::CMD_REMOVE_AT, 3'd0, 16'h0000, 4'd0));
      // Capacity zero acts as one; the list already holds more
      plan.push_back(cap_step(5'd0));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd1, 16'h5555, 4'd0));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd2, 16'haaaa, 4'd0));
      // Capacity above the depth acts as the depth
      plan.push_back(cap_step(5'd31));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd3, 16'h0f0f, 4'd0));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd4, 16'hf0f0, 4'd0));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd1, 16'h8001, 4'd0));
      // Lower the capacity below the count: one insert evicts several
      plan.push_back(cap_step(5'd2));
      plan.push_back(open_word(bol_pkg::CMD_INSERT, 3'd2, 16'h0001, 4'd0));
      plan.push_back(open_word(bol_pkg::CMD_READ, 3'd0, 16'h0000, 4'd15));
      plan.push_back(open_word(bol_pkg::CMD_REMOVE_AT, 3'd0, 16'h0000, 4'd1));

      // Hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table
      foreach (plan[i]) begin
         if (plan[i].what == STEP_CAP)
            set_capacity(plan[i].cap_value);
         else
            send_word(plan[i].cmd, plan[i].kind, plan[i].handle, plan[i].pos,
                      plan[i].fixed, plan[i].fixed_outcome);
      end

      // Random phases, one capacity each; even phases mostly fill the list
      phase_cap = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd16, 5'd2, 5'd0, 5'd5, 5'd0};
      for (ph = 0; ph < 10; ph++) begin
         if (ph == 7 || ph == 9)
            phase_cap[ph] = bol_pkg::count_type'($urandom_range(31));
         set_capacity(phase_cap[ph]);
         steady_run = (ph == 2 || ph == 3);
         ins_weight = (ph % 2 == 0) ? 70 : 45;
         for (j = 0; j < 48; j++) begin
            // Let the block run dry once in the middle of a phase
            if (ph == 5 && j == 24)
               wait_drained();
            roll = $urandom_range(99);
            if (roll < ins_weight)
               op = bol_pkg::CMD_INSERT;
            else if (roll < ins_weight + 15)
               op = bol_pkg::CMD_REMOVE_AT;
            else if (roll < ins_weight + 25)
               op = bol_pkg::CMD_PURGE;
            else
               op = bol_pkg::CMD_READ;
            if ($urandom_range(9) == 0)
               k = bol_pkg::kind_type'($urandom_range(7));
            else
               k = bol_pkg::kind_type'($urandom_range(bol_pkg::KIND_MAX,
                                                      bol_pkg::KIND_MIN));
            h = bol_pkg::handle_type'($urandom_range(16'hffff));
            // Mostly aim at a held entry
            if (shadow_len > 0 && $urandom_range(9) < 8)
               p = 4'($urandom_range(shadow_len - 1));
            else
               p = 4'($urandom_range(15));
            send_word(op, k, h, p, 1'b0, '0);
         end
      end
      steady_run = 1'b0;

      wait_drained();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Stop a hung run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
